// ===== rtl/cbcl_pkg.sv =====
`default_nettype none

package cbcl_pkg;

   // table geometry
   localparam int MAX_ENTRIES = 16;
   localparam int POS_W       = $clog2(MAX_ENTRIES) + 1;

   // fixed field widths
   localparam int VALUE_W = 32;
   localparam int COLOR_W = 32;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;
   localparam int TOL_W   = 16;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   // request opcodes
   localparam logic OP_CLASSIFY = 1'b0;
   localparam logic OP_WRITE    = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_MATCH  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NODATA = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BELOW  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ABOVE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_GAP    = 3'd4;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_CLASS_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_IS_NODATA  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ENTRY_COUNT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_TOLERANCE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NODATA_COLOR    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BELOW_COLOR     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ABOVE_COLOR     = 3'd6;

   localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

   // configuration as seen by the cells and the output stage
   typedef struct packed {
      logic               class_mode;
      logic [COUNT_W-1:0] count;
      logic [POS_W-1:0]   last_pos;
      logic [TOL_W-1:0]   tolerance;
      logic [COLOR_W-1:0] nodata_color;
      logic [COLOR_W-1:0] below_color;
      logic [COLOR_W-1:0] above_color;
   } cfg_type;

   // request token moving down the chain with its partial result
   typedef struct packed {
      logic                      valid;
      logic                      op;
      logic signed [VALUE_W-1:0] value;
      logic                      nodata;
      logic [INDEX_W-1:0]        wr_index;
      logic signed [VALUE_W-1:0] wr_lower;
      logic signed [VALUE_W-1:0] wr_upper;
      logic [COLOR_W-1:0]        wr_color;
      logic                      hit;
      logic [COLOR_W-1:0]        hit_color;
      logic [INDEX_W-1:0]        hit_index;
      logic                      below;
      logic                      last_eq;
      logic                      last_gt;
      logic [COLOR_W-1:0]        last_color;
   } token_type;

endpackage

`default_nettype wire

// ===== rtl/cbcl_req_if.sv =====
`default_nettype none

interface cbcl_req_if
   import cbcl_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic signed [VALUE_W-1:0] sample_value;
   logic                      sample_is_nan;
   logic [INDEX_W-1:0]        entry_index;
   logic signed [VALUE_W-1:0] entry_lower;
   logic signed [VALUE_W-1:0] entry_upper;
   logic [COLOR_W-1:0]        entry_color;

   modport source (
      output valid, op, sample_value, sample_is_nan, entry_index,
             entry_lower, entry_upper, entry_color,
      input  ready
   );

   modport sink (
      input  valid, op, sample_value, sample_is_nan, entry_index,
             entry_lower, entry_upper, entry_color,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/cbcl_rsp_if.sv =====
`default_nettype none

interface cbcl_rsp_if
   import cbcl_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [COLOR_W-1:0]  pixel_color;
   logic [INDEX_W-1:0]  class_index;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, pixel_color, class_index, status,
      input  ready
   );

   modport sink (
      input  valid, pixel_color, class_index, status,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/cbcl_cell.sv =====
`default_nettype none

module cbcl_cell
   import cbcl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [POS_W-1:0] cell_pos,
   input  wire cfg_type    cfg,
   input  wire token_type  tok_prev,
   output token_type       tok_ff
);

   logic signed [VALUE_W-1:0] lower_ff;
   logic signed [VALUE_W-1:0] upper_ff;
   logic [COLOR_W-1:0]        color_ff;

   token_type              tok_in;
   logic                   active;
   logic                   is_class;
   logic                   wr_hit;
   logic signed [VALUE_W:0] diff;
   logic signed [VALUE_W:0] tol_ext;
   logic                   cat_hit;
   logic                   num_hit;
   logic                   hit;

   // entry compare and partial result update
   always_comb begin
      active   = cell_pos < POS_W'(cfg.count);
      is_class = tok_prev.valid && (tok_prev.op == OP_CLASSIFY) && !tok_prev.nodata;
      wr_hit   = tok_prev.valid && (tok_prev.op == OP_WRITE) &&
                 (POS_W'(tok_prev.wr_index) == cell_pos);

      diff    = {tok_prev.value[VALUE_W-1], tok_prev.value} - {lower_ff[VALUE_W-1], lower_ff};
      tol_ext = $signed({{(VALUE_W + 1 - TOL_W){1'b0}}, cfg.tolerance});
      cat_hit = (diff <= tol_ext) && (diff >= -tol_ext);
      num_hit = (tok_prev.value >= lower_ff) && (tok_prev.value < upper_ff);
      hit     = cfg.class_mode ? cat_hit : num_hit;

      tok_in = tok_prev;
      if (is_class && active && !tok_prev.hit && hit) begin
         tok_in.hit       = 1'b1;
         tok_in.hit_color = color_ff;
         tok_in.hit_index = INDEX_W'(cell_pos);
      end
      // first entry decides the below case
      if (cell_pos == '0) begin
         tok_in.below = tok_prev.value < lower_ff;
      end
      // last valid entry decides the upper edge cases
      if (cell_pos == cfg.last_pos) begin
         tok_in.last_eq    = tok_prev.value == upper_ff;
         tok_in.last_gt    = tok_prev.value > upper_ff;
         tok_in.last_color = color_ff;
      end
   end

   // entry storage, loaded as a write request passes
   always_ff @(posedge clock) begin
      if (advance && wr_hit) begin
         lower_ff <= tok_prev.wr_lower;
         upper_ff <= tok_prev.wr_upper;
         color_ff <= tok_prev.wr_color;
      end
   end

   // token register
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cbcl_resolve.sv =====
`default_nettype none

module cbcl_resolve
   import cbcl_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire token_type tok_last,
   output logic           advance,
   cbcl_rsp_if.source     rsp_chan
);

   logic                rsp_valid_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic [STATUS_W-1:0] status_ff;

   logic [COLOR_W-1:0]  color_in;
   logic [INDEX_W-1:0]  index_in;
   logic [STATUS_W-1:0] status_in;

   // chain moves when the output slot is free or being drained
   assign advance = !rsp_valid_ff || rsp_chan.ready;

   // final selection in priority order
   always_comb begin
      color_in  = cfg.nodata_color;
      index_in  = '0;
      status_in = STATUS_GAP;
      if (tok_last.nodata) begin
         status_in = STATUS_NODATA;
      end else if (tok_last.hit) begin
         color_in  = tok_last.hit_color;
         index_in  = tok_last.hit_index;
         status_in = STATUS_MATCH;
      end else if (tok_last.below) begin
         color_in  = cfg.below_color;
         status_in = STATUS_BELOW;
      end else if (tok_last.last_eq) begin
         color_in  = tok_last.last_color;
         index_in  = INDEX_W'(cfg.last_pos);
         status_in = STATUS_MATCH;
      end else if (tok_last.last_gt) begin
         color_in  = cfg.above_color;
         status_in = STATUS_ABOVE;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tok_last.valid && (tok_last.op == OP_CLASSIFY);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff  <= color_in;
         index_ff  <= index_in;
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_color = color_ff;
   assign rsp_chan.class_index = index_ff;
   assign rsp_chan.status      = status_ff;

endmodule

`default_nettype wire

// ===== rtl/class_bin_color_lookup_core.sv =====
`default_nettype none

// Class color lookup over a chain of MAX_ENTRIES cells, one cell per table
// entry. Every request (classify or table write) enters cell 0 and moves one
// cell per cycle; a write loads its slot as it passes, so requests take effect
// strictly in order. A new request is taken every cycle unless the chain
// holds; a classify result passes the cell registers, then the output register.
// The whole chain holds while a result waits untaken in the output register.
// Write requests give no result. The table has no reset. The user must write
// registers on the csr port only while no request is in flight (not enforced).

module class_bin_color_lookup_core
   import cbcl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   cbcl_req_if.sink                   req_chan,
   cbcl_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   logic               class_mode_ff;
   logic               zero_is_nodata_ff;
   logic [COUNT_W-1:0] entry_count_ff;
   logic [TOL_W-1:0]   tolerance_ff;
   logic [COLOR_W-1:0] nodata_color_ff;
   logic [COLOR_W-1:0] below_color_ff;
   logic [COLOR_W-1:0] above_color_ff;

   cfg_type            cfg;
   logic [COUNT_W-1:0] count_eff;
   logic               advance;
   token_type          tok_head;
   token_type          chain [MAX_ENTRIES+1];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         class_mode_ff     <= 1'b0;
         zero_is_nodata_ff <= 1'b0;
         entry_count_ff    <= '0;
         tolerance_ff      <= TOL_RESET;
         nodata_color_ff   <= '0;
         below_color_ff    <= '0;
         above_color_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_CLASS_MODE:      class_mode_ff     <= csr_write_data[0];
            REG_ZERO_IS_NODATA:  zero_is_nodata_ff <= csr_write_data[0];
            REG_ENTRY_COUNT:     entry_count_ff    <= csr_write_data[COUNT_W-1:0];
            REG_MATCH_TOLERANCE: tolerance_ff      <= csr_write_data[TOL_W-1:0];
            REG_NODATA_COLOR:    nodata_color_ff   <= csr_write_data[COLOR_W-1:0];
            REG_BELOW_COLOR:     below_color_ff    <= csr_write_data[COLOR_W-1:0];
            REG_ABOVE_COLOR:     above_color_ff    <= csr_write_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // effective count, capped at the table depth
   always_comb begin
      if (POS_W'(entry_count_ff) > POS_W'(MAX_ENTRIES)) begin
         count_eff = COUNT_W'(MAX_ENTRIES);
      end else begin
         count_eff = entry_count_ff;
      end
      cfg.class_mode   = class_mode_ff;
      cfg.count        = count_eff;
      cfg.last_pos     = POS_W'(count_eff) - POS_W'(1);
      cfg.tolerance    = tolerance_ff;
      cfg.nodata_color = nodata_color_ff;
      cfg.below_color  = below_color_ff;
      cfg.above_color  = above_color_ff;
   end

   // token formed from the incoming request
   always_comb begin
      tok_head            = '0;
      tok_head.valid      = req_chan.valid;
      tok_head.op         = req_chan.op;
      tok_head.value      = req_chan.sample_value;
      tok_head.nodata     = req_chan.sample_is_nan ||
                            (zero_is_nodata_ff && (req_chan.sample_value == '0)) ||
                            (count_eff == '0);
      tok_head.wr_index   = req_chan.entry_index;
      tok_head.wr_lower   = req_chan.entry_lower;
      tok_head.wr_upper   = req_chan.entry_upper;
      tok_head.wr_color   = req_chan.entry_color;
   end

   assign req_chan.ready = advance;
   assign chain[0]       = tok_head;

   // one cell per table entry
   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
      cbcl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_pos (POS_W'(k)),
         .cfg      (cfg),
         .tok_prev (chain[k]),
         .tok_ff   (chain[k+1])
      );
   end

   cbcl_resolve u_resolve (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .tok_last (chain[MAX_ENTRIES]),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

   // a write leaving the chain never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      advance && chain[MAX_ENTRIES].valid && (chain[MAX_ENTRIES].op == OP_WRITE)
      |=> !rsp_chan.valid)
      else $error("write request produced a result");

   // a classify leaving the chain always produces a result
   a_classify_result: assert property (@(posedge clock) disable iff (reset)
      advance && chain[MAX_ENTRIES].valid && (chain[MAX_ENTRIES].op == OP_CLASSIFY)
      |=> rsp_chan.valid)
      else $error("classify request lost");

   // only a match carries a class index
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status != STATUS_MATCH) |-> (rsp_chan.class_index == '0))
      else $error("class index set without a match");

endmodule

`default_nettype wire
